// ===== rtl/day_number_to_gregorian_date_defines.svh =====
// Assertion helpers for the day number to date converter.
`ifndef DAY_NUMBER_TO_GREGORIAN_DATE_DEFINES_SVH
`define DAY_NUMBER_TO_GREGORIAN_DATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DNG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DNG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dng_pkg.sv =====
`timescale 1ns / 1ps

package dng_pkg;

    // Datapath widths
    localparam int DAY_W  = 32;
    localparam int DAYS_W = 33;
    localparam int ALU_W  = 19;
    localparam int LOW_W  = 15;
    localparam int CYC_W  = 15;
    localparam int YRS_W  = 7;
    localparam int YEAR_W = 24;
    localparam int DOY_W  = 9;
    localparam int CNT_W  = 4;

    // Calendar constants
    localparam logic [ALU_W-1:0]  CYCLE400_DAYS  = 19'd146097;
    localparam logic [ALU_W-1:0]  QDAYS_PER_YEAR = 19'd1461;
    localparam logic [DAYS_W-1:0] EPOCH_OFFSET   = 33'd36524;
    localparam logic [YEAR_W-1:0] BASE_YEAR      = 24'd1501;
    localparam logic [YEAR_W-1:0] CENT_YEARS     = 24'd100;
    localparam logic [YEAR_W-1:0] CYCLE_YEARS    = 24'd400;
    localparam logic [YRS_W-1:0]  LAST_CENT_YRS  = 7'd99;
    localparam logic [DOY_W-1:0]  FEB_END_BIASED = 9'd59;
    localparam logic [3:0]        LAST_MONTH     = 4'd12;

    // Division step counts (quotient bits of each pass)
    localparam logic [CNT_W-1:0] CYC_STEPS  = 4'd15;
    localparam logic [CNT_W-1:0] CENT_STEPS = 4'd2;
    localparam logic [CNT_W-1:0] YEAR_STEPS = 4'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_CYC,
        S_LD_CENT,
        S_DIV_CENT,
        S_LD_YEAR,
        S_DIV_YEAR,
        S_CALC,
        S_CHECK,
        S_MONTH,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DSEL_CYCLE,
        DSEL_YEAR,
        DSEL_MONTH
    } t_dsel;

    typedef struct packed {
        logic  load;
        logic  div_step;
        logic  ld_cent;
        logic  ld_year;
        logic  calc;
        logic  check;
        logic  month_step;
        logic  done;
        t_dsel dsel;
    } t_ctrl;

    typedef struct packed {
        logic month_hit;
        logic over;
    } t_stat;

    // Month lengths with February biased to 29 days; index 0 is January
    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        unique case (idx)
            4'd1:    len = 5'd29;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/day_number_to_gregorian_date.sv =====
`timescale 1ns / 1ps
// Each word runs the division passes, year assembly and range check, then walks the
// months from January; a range error skips the walk and clears the date fields.
// A new word is accepted only while idle; the shared subtractor runs 24 restoring
// division steps and up to 12 month steps one at a time. Results are never stalled.
// Reset: i_rst_n is synchronous, active low, and returns the sequencer to idle.
module day_number_to_gregorian_date import dng_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [DAY_W-1:0] i_day_count,
    output logic             o_valid,
    output logic [15:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day_of_month,
    output logic             o_range_error
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    logic [ALU_W-1:0]  r_rem;
    logic [LOW_W-1:0]  r_low;
    logic [CYC_W-1:0]  r_quo;
    logic [CYC_W-1:0]  r_cyc;
    logic [1:0]        r_cent;
    logic [YEAR_W-1:0] r_year;
    logic [DOY_W-1:0]  r_doy;
    logic [3:0]        r_mon;
    logic              r_leap;
    logic              r_err;

    logic [ALU_W-1:0]  w_a, w_b, w_diff;
    logic              w_ge;
    logic [DAYS_W-1:0] w_days;
    logic [17:0]       w_qy;
    logic [7:0]        w_yrs_p1;
    logic              w_leap;
    logic [4:0]        w_mlen;

    dng_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy)
    );

    // Select operands for the shared subtractor
    assign w_mlen = month_len(r_mon - 4'd1);
    always_comb begin
        w_a = {r_rem[ALU_W-2:0], r_low[LOW_W-1]};
        unique case (w_ctrl.dsel)
            DSEL_CYCLE: w_b = CYCLE400_DAYS;
            DSEL_YEAR:  w_b = QDAYS_PER_YEAR;
            DSEL_MONTH: begin
                w_a = ALU_W'(r_doy);
                w_b = ALU_W'(w_mlen);
            end
            default:    w_b = CYCLE400_DAYS;
        endcase
    end

    dng_sub u_sub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    // Derived values for load, reload and year assembly
    assign w_days   = DAYS_W'(i_day_count) + EPOCH_OFFSET;
    assign w_qy     = r_rem[17:0] | 18'd3;
    assign w_yrs_p1 = {1'b0, r_quo[YRS_W-1:0]} + 8'd1;
    assign w_leap   = (w_yrs_p1[1:0] == 2'd0) &&
                      ((r_quo[YRS_W-1:0] != LAST_CENT_YRS) || (r_cent == 2'd0));

    // Report to the sequencer
    assign w_stat.month_hit = !w_ge || (w_diff == '0) || (r_mon == LAST_MONTH);
    assign w_stat.over      = |r_year[YEAR_W-1:16];

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_rem <= ALU_W'(w_days[DAYS_W-1:LOW_W]);
            r_low <= w_days[LOW_W-1:0];
            r_quo <= '0;
        end else if (w_ctrl.div_step) begin
            // One restoring division step: keep difference when it fits
            r_rem <= w_ge ? w_diff : w_a;
            r_quo <= {r_quo[CYC_W-2:0], w_ge};
            r_low <= {r_low[LOW_W-2:0], 1'b0};
        end else if (w_ctrl.ld_cent) begin
            // Quarter days: remainder times four, so two zero bits follow
            r_cyc <= r_quo;
            r_low <= '0;
            r_quo <= '0;
        end else if (w_ctrl.ld_year) begin
            r_cent <= r_quo[1:0];
            r_rem  <= ALU_W'(w_qy[17:YRS_W]);
            r_low  <= {w_qy[YRS_W-1:0], 8'd0};
            r_quo  <= '0;
        end else if (w_ctrl.calc) begin
            r_year <= BASE_YEAR + YEAR_W'(r_quo[YRS_W-1:0])
                      + YEAR_W'(r_cent) * CENT_YEARS + YEAR_W'(r_cyc) * CYCLE_YEARS;
            r_doy  <= DOY_W'(r_rem[10:2]) + 9'd1;
            r_leap <= w_leap;
        end else if (w_ctrl.check) begin
            if (w_stat.over) begin
                r_err  <= 1'b1;
                r_year <= '0;
                r_mon  <= '0;
                r_doy  <= '0;
            end else begin
                r_err <= 1'b0;
                r_mon <= 4'd1;
                // Skip the table's February 29 in common years
                if (!r_leap && (r_doy > FEB_END_BIASED)) r_doy <= r_doy + 9'd1;
            end
        end else if (w_ctrl.month_step) begin
            if (!w_stat.month_hit) begin
                r_doy <= w_diff[DOY_W-1:0];
                r_mon <= r_mon + 4'd1;
            end
        end
    end

    // Drive the result word
    assign o_valid        = w_ctrl.done;
    assign o_year         = r_year[15:0];
    assign o_month        = r_mon;
    assign o_day_of_month = r_doy[4:0];
    assign o_range_error  = r_err;

endmodule

// ===== rtl/dng_sub.sv =====
`timescale 1ns / 1ps

module dng_sub import dng_pkg::*; (
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    output logic [ALU_W-1:0] o_diff,
    output logic             o_ge
);

    logic [ALU_W:0] w_full;

    // Subtract with borrow out; no borrow means a >= b
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[ALU_W-1:0];
    assign o_ge   = ~w_full[ALU_W];

endmodule

// ===== rtl/dng_fsm.sv =====
`timescale 1ns / 1ps

module dng_fsm import dng_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Hold state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and step count
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DIV_CYC;
                    n_cnt   = CYC_STEPS - 4'd1;
                end
            end
            S_DIV_CYC: begin
                if (r_cnt == '0) n_state = S_LD_CENT;
                else n_cnt = r_cnt - 4'd1;
            end
            S_LD_CENT: begin
                n_state = S_DIV_CENT;
                n_cnt   = CENT_STEPS - 4'd1;
            end
            S_DIV_CENT: begin
                if (r_cnt == '0) n_state = S_LD_YEAR;
                else n_cnt = r_cnt - 4'd1;
            end
            S_LD_YEAR: begin
                n_state = S_DIV_YEAR;
                n_cnt   = YEAR_STEPS - 4'd1;
            end
            S_DIV_YEAR: begin
                if (r_cnt == '0) n_state = S_CALC;
                else n_cnt = r_cnt - 4'd1;
            end
            S_CALC:  n_state = S_CHECK;
            S_CHECK: n_state = i_stat.over ? S_DONE : S_MONTH;
            S_MONTH: begin
                if (i_stat.month_hit) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Decode controls from state
    always_comb begin
        o_ctrl = '{load: 1'b0, div_step: 1'b0, ld_cent: 1'b0, ld_year: 1'b0,
                   calc: 1'b0, check: 1'b0, month_step: 1'b0, done: 1'b0,
                   dsel: DSEL_CYCLE};
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy      = 1'b0;
                o_ctrl.load = i_start;
            end
            S_DIV_CYC:  o_ctrl.div_step = 1'b1;
            S_LD_CENT:  o_ctrl.ld_cent  = 1'b1;
            S_DIV_CENT: o_ctrl.div_step = 1'b1;
            S_LD_YEAR:  o_ctrl.ld_year  = 1'b1;
            S_DIV_YEAR: begin
                o_ctrl.div_step = 1'b1;
                o_ctrl.dsel     = DSEL_YEAR;
            end
            S_CALC:  o_ctrl.calc  = 1'b1;
            S_CHECK: o_ctrl.check = 1'b1;
            S_MONTH: begin
                o_ctrl.month_step = 1'b1;
                o_ctrl.dsel       = DSEL_MONTH;
            end
            S_DONE:  o_ctrl.done = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

endmodule

// ===== rtl/dng_chk.sv =====
`timescale 1ns / 1ps
`include "day_number_to_gregorian_date_defines.svh"

module dng_chk import dng_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [DAY_W-1:0] i_day_count,
    input logic             o_valid,
    input logic [15:0]      o_year,
    input logic [3:0]       o_month,
    input logic [4:0]       o_day_of_month,
    input logic             o_range_error
);

    // An accepted word keeps the block busy
    `DNG_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept did not raise busy")

    // A result shows for one cycle only
    `DNG_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid && !busy, "result strobe held")

    // Range error clears all date fields
    `DNG_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_range_error, (o_year == 16'd0) && (o_month == 4'd0) && (o_day_of_month == 5'd0), "range error with nonzero date")

    // A good date has month 1..12 and a day of at least 1
    `DNG_ASSERT_NOW(a_date_ok, i_clk, i_rst_n, o_valid && !o_range_error, (o_month != 4'd0) && (o_month <= 4'd12) && (o_day_of_month != 5'd0), "date out of range")

    // No result without an item in flight
    `DNG_ASSERT_NOW(a_valid_busy, i_clk, i_rst_n, o_valid, busy, "strobe while idle")

endmodule

bind day_number_to_gregorian_date dng_chk u_chk (.*);

// ===== test/day_number_to_gregorian_date_tb.sv =====
`timescale 1ns / 1ps

module day_number_to_gregorian_date_tb;
    import dng_pkg::DAY_W;

    // Calendar arithmetic used by the date predictor
    localparam longint unsigned EPOCH_SHIFT  = 36524;   // 1501-01-01 to 1600-12-31
    localparam longint unsigned DAYS_PER_400 = 146097;
    localparam longint unsigned QDAYS_4YR    = 1461;
    localparam longint unsigned FIRST_YEAR   = 1501;
    localparam longint unsigned MAX_YEAR     = 65535;
    localparam longint unsigned FEB_END      = 59;

    // Day numbers on either side of the year overflow
    localparam logic [DAY_W-1:0] LAST_GOOD_DAY = 32'd23351778;  // 65535-12-31
    localparam logic [DAY_W-1:0] FIRST_BAD_DAY = 32'd23351779;  // 65536-01-01

    localparam int RANDOM_WORDS = 1150;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic        err;
    } t_date;

    typedef struct packed {
        logic [DAY_W-1:0] days;
        logic             typed;
        t_date            want;
    } t_dir_row;

    localparam t_date OUT_OF_RANGE = '{year: 16'd0, month: 4'd0, mday: 5'd0, err: 1'b1};

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [DAY_W-1:0] i_day_count;
    logic             o_valid;
    logic [15:0]      o_year;
    logic [3:0]       o_month;
    logic [4:0]       o_day_of_month;
    logic             o_range_error;

    t_date pending_dates[$];
    int    mismatches = 0;

    day_number_to_gregorian_date dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_day_count    (i_day_count),
        .o_valid        (o_valid),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_range_error  (o_range_error)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Convert a day number to a calendar date, or flag the year overflow
    function automatic t_date date_of_day(input logic [DAY_W-1:0] dn);
        longint unsigned span, cyc, qd, cent, qy, yrs, doy, yr;
        int unsigned     mlen[12];
        logic            leap;
        logic            found;
        t_date           d;
        mlen = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        span = dn;
        span = span + EPOCH_SHIFT;
        cyc  = span / DAYS_PER_400;
        qd   = (span % DAYS_PER_400) * 4;
        cent = qd / DAYS_PER_400;
        qy   = (qd % DAYS_PER_400) | 64'd3;
        yrs  = qy / QDAYS_4YR;
        doy  = (qy % QDAYS_4YR) / 4 + 1;
        yr   = FIRST_YEAR + yrs + 100 * (cent + 4 * cyc);
        if (yr > MAX_YEAR) begin
            return OUT_OF_RANGE;
        end
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        // Skip the table's February 29 outside leap years
        if (!leap && doy > FEB_END) doy = doy + 1;
        d.month = 4'd12;
        found = 1'b0;
        for (int k = 0; k < 12; k++) begin
            if (!found) begin
                if (doy <= mlen[k]) begin
                    d.month = 4'(k + 1);
                    found = 1'b1;
                end else begin
                    doy = doy - mlen[k];
                end
            end
        end
        d.year = yr[15:0];
        d.mday = doy[4:0];
        d.err  = 1'b0;
        return d;
    endfunction

    // Draw a day number: mostly in range, some near the overflow, some anywhere
    function automatic logic [DAY_W-1:0] pick_day();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return $urandom_range(0, LAST_GOOD_DAY);
        if (sel == 5) return $urandom_range(LAST_GOOD_DAY - 800, FIRST_BAD_DAY + 800);
        if (sel == 6) return $urandom_range(0, 200000);
        return $urandom;
    endfunction

    // Present one word, hold it until accepted, then record its expected date
    task automatic send_word(input logic [DAY_W-1:0] dn, input t_date want,
                             input int gap, input logic after_idle);
        logic was_busy;
        if (gap > 0 || after_idle) start <= 1'b0;
        if (after_idle) begin
            do begin
                @(negedge i_clk);
                was_busy = busy;
                @(posedge i_clk);
            end while (was_busy);
        end
        repeat (gap) @(posedge i_clk);
        start       <= 1'b1;
        i_day_count <= dn;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
        pending_dates.push_back(want);
    endtask

    // Check each result strobe against the oldest expected date
    always @(posedge i_clk) begin
        t_date want;
        if (i_rst_n && o_valid) begin
            if (pending_dates.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: expected none, got year=%0d month=%0d %s%0d err=%0b",
                         $time, o_year, o_month, "day=", o_day_of_month, o_range_error);
            end else begin
                want = pending_dates.pop_front();
                if (o_year !== want.year || o_month !== want.month ||
                    o_day_of_month !== want.mday || o_range_error !== want.err) begin
                    mismatches++;
                    $display("%0t: mismatch: expected %0d-%0d-%0d err=%0b, %s%0d-%0d-%0d err=%0b",
                             $time, want.year, want.month, want.mday, want.err,
                             "got ", o_year, o_month, o_day_of_month, o_range_error);
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row         rows[21];
        logic [DAY_W-1:0] dn;
        t_date            want;
        int               gap;
        int               guard;
        logic             burst;

        start       = 1'b0;
        i_day_count = '0;
        i_rst_n     = 1'b0;

        // Edge dates typed in; the rest go through the predictor
        rows[0]  = '{32'd0,          1'b1, '{16'd1600, 4'd12, 5'd31, 1'b0}};
        rows[1]  = '{32'd1,          1'b1, '{16'd1601, 4'd1,  5'd1,  1'b0}};
        rows[2]  = '{32'hFFFF_FFFF,  1'b1, OUT_OF_RANGE};
        rows[3]  = '{LAST_GOOD_DAY,  1'b1, '{16'd65535, 4'd12, 5'd31, 1'b0}};
        rows[4]  = '{FIRST_BAD_DAY,  1'b1, OUT_OF_RANGE};
        rows[5]  = '{32'd59,         1'b0, '0};  // end of February, common year
        rows[6]  = '{32'd60,         1'b0, '0};
        rows[7]  = '{32'd365,        1'b0, '0};
        rows[8]  = '{32'd1155,       1'b0, '0};  // leap day
        rows[9]  = '{32'd1156,       1'b0, '0};
        rows[10] = '{32'd36218,      1'b0, '0};  // century year, not leap
        rows[11] = '{32'd36219,      1'b0, '0};
        rows[12] = '{32'd145791,     1'b0, '0};  // 400-year leap day
        rows[13] = '{32'd145792,     1'b0, '0};
        rows[14] = '{32'd146097,     1'b0, '0};
        rows[15] = '{32'h5555_5555,  1'b0, '0};
        rows[16] = '{32'hAAAA_AAAA,  1'b0, '0};
        rows[17] = '{32'h7FFF_FFFF,  1'b0, '0};
        rows[18] = '{32'h8000_0000,  1'b0, '0};
        rows[19] = '{32'h0000_FFFF,  1'b0, '0};
        rows[20] = '{32'h00FF_FFFF,  1'b0, '0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (rows[r]) begin
            want = rows[r].typed ? rows[r].want : date_of_day(rows[r].days);
            send_word(rows[r].days, want, $urandom_range(0, 4), 1'($urandom_range(0, 1)));
        end

        // Random words, with stretches of back-to-back requests
        burst = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            dn  = pick_day();
            gap = burst ? 0 : $urandom_range(0, 4);
            send_word(dn, date_of_day(dn), gap, burst ? 1'b0 : 1'($urandom_range(0, 1)));
        end
        start <= 1'b0;

        // Drain outstanding results, then let the block settle
        guard = 0;
        while (pending_dates.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        if (pending_dates.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected words never arrived", $time, pending_dates.size());
        end
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
